[hdl/mmps_pkg.sv]
package mmps_pkg;

   localparam int MAX_CUTS_DEF    = 1024;
   localparam int LENGTH_BITS_DEF = 30;
   localparam int CUTS_W          = 11;
   localparam int NEED_W          = CUTS_W + 1;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic {
      CSR_TOTAL_LENGTH = 1'b0,
      CSR_CUTS_TO_MAKE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_MID,
      ST_SCAN,
      ST_DONE
   } search_state_type;

endpackage

[hdl/max_min_partition_search.sv]
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_cut_position, req_last_cut
// rsp       out        rsp_valid/rsp_stall   rsp_best_length, rsp_overflow
// csr       in         csr_wr_en             csr_index, csr_wdata
//
// A cut position is written to the piece store on acceptance unless the store is full.
// A last request hands a job to the search engine, which walks the stored pieces one
// per cycle through the store's read port in each bisection step, and there are about
// log2(total_length) steps.
// req_stall is high from the last request until the result moves to the output register.
// Reset is synchronous and clears control state only; the store needs no clearing.
module max_min_partition_search #(
   parameter int MAX_CUTS    = mmps_pkg::MAX_CUTS_DEF,
   parameter int LENGTH_BITS = mmps_pkg::LENGTH_BITS_DEF,
   localparam int CSR_W = (LENGTH_BITS > mmps_pkg::CUTS_W) ? LENGTH_BITS : mmps_pkg::CUTS_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [LENGTH_BITS-1:0] req_cut_position,
   input  logic                   req_last_cut,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LENGTH_BITS-1:0] rsp_best_length,
   output logic                   rsp_overflow
);

   localparam int IDX_W  = $clog2(MAX_CUTS + 1);
   localparam int ADDR_W = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;
   localparam int JOB_W  = IDX_W + 2 * LENGTH_BITS + mmps_pkg::NEED_W + 1;

   logic                   hold;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [LENGTH_BITS-1:0] wr_data;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [LENGTH_BITS-1:0] rd_data;
   logic                   push;
   logic [JOB_W-1:0]       push_data;
   logic                   pop;
   logic [JOB_W-1:0]       pop_data;
   logic                   q_empty;
   logic                   back_busy;

   // hold new requests while a set is queued or being searched
   assign hold = !q_empty || back_busy;

   mmps_front #(
      .MAX_CUTS    (MAX_CUTS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cut_position (req_cut_position),
      .req_last_cut     (req_last_cut),
      .hold             (hold),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .push             (push),
      .push_data        (push_data)
   );

   mmps_store #(
      .DEPTH  (MAX_CUTS),
      .ADDR_W (ADDR_W),
      .DATA_W (LENGTH_BITS)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   mmps_queue #(
      .DEPTH (mmps_pkg::QUEUE_DEPTH),
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   mmps_back #(
      .MAX_CUTS    (MAX_CUTS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_avail       (!q_empty),
      .pop             (pop),
      .pop_data        (pop_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .busy            (back_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_best_length (rsp_best_length),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

[hdl/mmps_store.sv]
module mmps_store #(
   parameter int DEPTH  = mmps_pkg::MAX_CUTS_DEF,
   parameter int ADDR_W = 10,
   parameter int DATA_W = mmps_pkg::LENGTH_BITS_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[hdl/mmps_queue.sv]
module mmps_queue #(
   parameter int DEPTH = mmps_pkg::QUEUE_DEPTH,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slots_ff[rd_ptr_ff];
   assign empty    = (fill_ff == '0);

endmodule

[hdl/mmps_front.sv]
module mmps_front #(
   parameter int MAX_CUTS    = mmps_pkg::MAX_CUTS_DEF,
   parameter int LENGTH_BITS = mmps_pkg::LENGTH_BITS_DEF,
   localparam int IDX_W  = $clog2(MAX_CUTS + 1),
   localparam int ADDR_W = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1,
   localparam int CSR_W  = (LENGTH_BITS > mmps_pkg::CUTS_W) ? LENGTH_BITS : mmps_pkg::CUTS_W,
   localparam int JOB_W  = IDX_W + 2 * LENGTH_BITS + mmps_pkg::NEED_W + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [LENGTH_BITS-1:0] req_cut_position,
   input  logic                   req_last_cut,
   input  logic                   hold,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [LENGTH_BITS-1:0] wr_data,
   output logic                   push,
   output logic [JOB_W-1:0]       push_data
);

   localparam int CUTS_W = mmps_pkg::CUTS_W;
   localparam int NEED_W = mmps_pkg::NEED_W;

   logic [LENGTH_BITS-1:0] total_ff, total_in;
   logic [CUTS_W-1:0]      cuts_ff, cuts_in;
   logic [IDX_W-1:0]       loaded_ff, loaded_in;
   logic [LENGTH_BITS-1:0] prev_ff, prev_in;
   logic                   dropped_ff, dropped_in;

   logic                   accept;
   logic                   full;
   logic [LENGTH_BITS-1:0] piece;
   logic [LENGTH_BITS-1:0] base;
   logic [LENGTH_BITS-1:0] final_piece;
   logic [NEED_W-1:0]      need;
   logic [IDX_W-1:0]       count;

   assign req_stall = hold;
   assign accept    = req_valid && !hold;
   assign full      = (loaded_ff == IDX_W'(MAX_CUTS));

   assign piece       = (req_cut_position > prev_ff) ? req_cut_position - prev_ff : '0;
   // a dropped last request leaves the final piece anchored at the last stored cut
   assign base        = full ? prev_ff : req_cut_position;
   assign final_piece = (total_ff > base) ? total_ff - base : '0;
   assign need        = NEED_W'(cuts_ff) + NEED_W'(1);
   assign count       = full ? loaded_ff : loaded_ff + IDX_W'(1);

   always_comb begin
      total_in = total_ff;
      cuts_in  = cuts_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mmps_pkg::CSR_TOTAL_LENGTH: total_in = csr_wdata[LENGTH_BITS-1:0];
            mmps_pkg::CSR_CUTS_TO_MAKE: cuts_in  = csr_wdata[CUTS_W-1:0];
            default:                    total_in = total_ff;
         endcase
      end
   end

   always_comb begin
      loaded_in  = loaded_ff;
      prev_in    = prev_ff;
      dropped_in = dropped_ff;
      if (accept) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            loaded_in = loaded_ff + IDX_W'(1);
            prev_in   = req_cut_position;
         end
         if (req_last_cut) begin
            loaded_in  = '0;
            prev_in    = '0;
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '1;
         cuts_ff    <= CUTS_W'(1);
         loaded_ff  <= '0;
         prev_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         total_ff   <= total_in;
         cuts_ff    <= cuts_in;
         loaded_ff  <= loaded_in;
         prev_ff    <= prev_in;
         dropped_ff <= dropped_in;
      end
   end

   assign wr_en     = accept && !full;
   assign wr_addr   = loaded_ff[ADDR_W-1:0];
   assign wr_data   = piece;
   assign push      = accept && req_last_cut;
   assign push_data = {count, final_piece, total_ff, need, dropped_ff | full};

endmodule

[hdl/mmps_back.sv]
module mmps_back #(
   parameter int MAX_CUTS    = mmps_pkg::MAX_CUTS_DEF,
   parameter int LENGTH_BITS = mmps_pkg::LENGTH_BITS_DEF,
   localparam int IDX_W  = $clog2(MAX_CUTS + 1),
   localparam int ADDR_W = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1,
   localparam int JOB_W  = IDX_W + 2 * LENGTH_BITS + mmps_pkg::NEED_W + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_avail,
   output logic                   pop,
   input  logic [JOB_W-1:0]       pop_data,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   input  logic [LENGTH_BITS-1:0] rd_data,
   output logic                   busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LENGTH_BITS-1:0] rsp_best_length,
   output logic                   rsp_overflow
);

   localparam int L      = LENGTH_BITS;
   localparam int NEED_W = mmps_pkg::NEED_W;

   mmps_pkg::search_state_type state_ff, state_in;

   logic [IDX_W-1:0]  j_count;
   logic [L-1:0]      j_final;
   logic [L-1:0]      j_total;
   logic [NEED_W-1:0] j_need;
   logic              j_drop;

   logic [IDX_W-1:0]  count_ff, count_in;
   logic [L-1:0]      final_ff, final_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              drop_ff, drop_in;
   logic [L-1:0]      lo_ff, lo_in;
   logic [L-1:0]      hi_ff, hi_in;
   logic [L-1:0]      half_ff, half_in;
   logic [L-1:0]      m_ff, m_in;
   logic [L:0]        cur_ff, cur_in;
   logic [NEED_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]  iss_idx_ff, iss_idx_in;
   logic              iss_on_ff, iss_on_in;
   logic              tag_v_ff, tag_v_in;
   logic              tag_final_ff, tag_final_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [L-1:0]      best_ff, best_in;
   logic              ovf_ff, ovf_in;

   logic [L-1:0]      span;
   logic              span_big;
   logic [L:0]        piece;
   logic [L:0]        sum;
   logic              hit;
   logic [NEED_W-1:0] cnt_inc;
   logic              good;
   logic              step_end;
   logic              rsp_load;

   assign {j_count, j_final, j_total, j_need, j_drop} = pop_data;

   assign span     = hi_ff - lo_ff;
   assign span_big = (span > L'(1));

   // the last piece of a set lives in the job, not in the store
   assign piece    = tag_final_ff ? {1'b0, final_ff} : {1'b0, rd_data};
   assign sum      = cur_ff + piece;
   assign hit      = (sum >= {1'b0, m_ff});
   assign cnt_inc  = cnt_ff + NEED_W'(1);
   assign good     = hit && (cnt_inc >= need_ff);
   assign step_end = tag_v_ff && (good || tag_final_ff);
   assign rsp_load = (state_ff == mmps_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mmps_pkg::ST_IDLE: if (pop_avail) state_in = mmps_pkg::ST_SPAN;
         mmps_pkg::ST_SPAN: state_in = span_big ? mmps_pkg::ST_MID : mmps_pkg::ST_DONE;
         mmps_pkg::ST_MID:  state_in = mmps_pkg::ST_SCAN;
         mmps_pkg::ST_SCAN: if (step_end) state_in = mmps_pkg::ST_SPAN;
         mmps_pkg::ST_DONE: if (rsp_load) state_in = mmps_pkg::ST_IDLE;
         default:           state_in = mmps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      rd_en        = 1'b0;
      count_in     = count_ff;
      final_in     = final_ff;
      need_in      = need_ff;
      drop_in      = drop_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      half_in      = half_ff;
      m_in         = m_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      iss_idx_in   = iss_idx_ff;
      iss_on_in    = iss_on_ff;
      tag_v_in     = 1'b0;
      tag_final_in = tag_final_ff;
      unique case (state_ff)
         mmps_pkg::ST_IDLE: begin
            if (pop_avail) begin
               pop      = 1'b1;
               count_in = j_count;
               final_in = j_final;
               need_in  = j_need;
               drop_in  = j_drop;
               lo_in    = '0;
               hi_in    = j_total;
            end
         end
         mmps_pkg::ST_SPAN: begin
            half_in = span >> 1;
         end
         mmps_pkg::ST_MID: begin
            m_in       = lo_ff + half_ff;
            iss_idx_in = '0;
            iss_on_in  = 1'b1;
            cur_in     = '0;
            cnt_in     = '0;
         end
         mmps_pkg::ST_SCAN: begin
            if (iss_on_ff) begin
               rd_en        = (iss_idx_ff != count_ff);
               tag_v_in     = 1'b1;
               tag_final_in = (iss_idx_ff == count_ff);
               if (iss_idx_ff == count_ff) begin
                  iss_on_in = 1'b0;
               end else begin
                  iss_idx_in = iss_idx_ff + IDX_W'(1);
               end
            end
            if (tag_v_ff) begin
               if (good) begin
                  lo_in     = m_ff;
                  iss_on_in = 1'b0;
                  tag_v_in  = 1'b0;
               end else if (tag_final_ff) begin
                  hi_in     = m_ff;
                  iss_on_in = 1'b0;
                  tag_v_in  = 1'b0;
               end else if (hit) begin
                  cur_in = '0;
                  cnt_in = cnt_inc;
               end else begin
                  cur_in = sum;
               end
            end
         end
         mmps_pkg::ST_DONE: begin
            iss_on_in = 1'b0;
         end
         default: begin
            iss_on_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         best_in      = lo_ff;
         ovf_in       = drop_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmps_pkg::ST_IDLE;
         iss_on_ff    <= 1'b0;
         tag_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_on_ff    <= iss_on_in;
         tag_v_ff     <= tag_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      final_ff     <= final_in;
      need_ff      <= need_in;
      drop_ff      <= drop_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      half_ff      <= half_in;
      m_ff         <= m_in;
      cur_ff       <= cur_in;
      cnt_ff       <= cnt_in;
      iss_idx_ff   <= iss_idx_in;
      tag_final_ff <= tag_final_in;
      best_ff      <= best_in;
      ovf_ff       <= ovf_in;
   end

   assign rd_addr         = iss_idx_ff[ADDR_W-1:0];
   assign busy            = (state_ff != mmps_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_length = best_ff;
   assign rsp_overflow    = ovf_ff;

endmodule

[tb/sv/max_min_partition_search_tb.sv]
`timescale 1ns / 100ps

module max_min_partition_search_tb;

   localparam int LB          = mmps_pkg::LENGTH_BITS_DEF;
   localparam int MAXC        = mmps_pkg::MAX_CUTS_DEF;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int HOLD_CYCLES = 3000;
   localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
   localparam logic [LB-1:0] POS_MAX = LEN_MAX - 1;

   typedef struct {
      logic [LB-1:0] pos;
      logic          is_last;
   } cut_item_type;

   typedef struct {
      logic [LB-1:0] best;
      logic          ovf;
   } answer_type;

   logic          clock;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   logic          csr_index = 1'b0;
   logic [LB-1:0] csr_wdata = '0;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [LB-1:0] req_cut_position = '0;
   logic          req_last_cut = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [LB-1:0] rsp_best_length;
   logic          rsp_overflow;

   // stimulus and expectations
   cut_item_type cut_backlog[$];
   answer_type   due_answers[$];
   int unsigned  queued_cuts   = 0;
   int unsigned  accepted_cuts = 0;
   int unsigned  fail_count    = 0;
   int unsigned  cycle_count   = 0;

   // idling state
   int unsigned send_gap  = 0;
   int unsigned send_calm = 0;
   int unsigned stall_left = 0;
   int unsigned stall_calm = 0;
   int unsigned hold_left  = 0;
   logic        hold_req   = 1'b0;
   logic        hold_spent = 1'b0;

   // partition model state
   logic [LB-1:0] piece_store [0:MAXC];
   int unsigned   stored_pieces = 0;
   logic [LB-1:0] last_position = '0;
   logic          dropped = 1'b0;
   logic [LB-1:0] bar_length = LEN_MAX;
   logic [10:0]   cut_count = 11'd1;

   max_min_partition_search DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cut_position (req_cut_position),
      .req_last_cut     (req_last_cut),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_best_length  (rsp_best_length),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [LB-1:0] gap_len(logic [LB-1:0] a, logic [LB-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   // greedy left-to-right: close a piece once the running sum reaches m
   function automatic bit splits_into(longint unsigned m, int unsigned pieces);
      longint unsigned run_len;
      longint unsigned closed;
      run_len = 0;
      closed = 0;
      for (int unsigned i = 0; i < pieces; i++) begin
         run_len += piece_store[i];
         if (run_len >= m) begin
            closed++;
            run_len = 0;
            if (closed >= cut_count + 64'd1) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void take_cut(logic [LB-1:0] pos, logic is_last);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      answer_type ans;
      if (stored_pieces < MAXC) begin
         piece_store[stored_pieces] = gap_len(pos, last_position);
         stored_pieces++;
         last_position = pos;
      end else begin
         dropped = 1'b1;
      end
      if (is_last) begin
         piece_store[stored_pieces] = gap_len(bar_length, last_position);
         lo = 0;
         hi = bar_length;
         while (hi - lo > 1) begin
            mid = lo + ((hi - lo) >> 1);
            if (splits_into(mid, stored_pieces + 1)) lo = mid;
            else hi = mid;
         end
         ans.best = lo[LB-1:0];
         ans.ovf = dropped;
         due_answers.push_back(ans);
         stored_pieces = 0;
         last_position = '0;
         dropped = 1'b0;
      end
   endfunction

   function automatic void note_failure(string what, answer_type want);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch (%s): expected length %0d overflow %0b, got length %0d overflow %0b",
                  what, want.best, want.ovf, rsp_best_length, rsp_overflow);
   endfunction

   // request driver
   always @(posedge clock) begin : drive
      cut_item_type nxt;
      logic         nxt_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nxt_valid = req_valid;
         if (req_valid && !req_stall) begin
            take_cut(req_cut_position, req_last_cut);
            accepted_cuts++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
            end else if (cut_backlog.size() != 0) begin
               nxt = cut_backlog.pop_front();
               req_cut_position <= nxt.pos;
               req_last_cut <= nxt.is_last;
               nxt_valid = 1'b1;
               if (send_calm != 0) begin
                  send_calm <= send_calm - 1;
               end else begin
                  send_gap <= pick_gap();
                  if ($urandom_range(0, 49) == 0) send_calm <= $urandom_range(40, 150);
               end
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // result monitor and stall pattern
   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_answers.size() == 0) begin
               want.best = '0;
               want.ovf = 1'b0;
               note_failure("unexpected result", want);
            end else begin
               want = due_answers.pop_front();
               if (rsp_best_length !== want.best || rsp_overflow !== want.ovf)
                  note_failure("wrong field", want);
            end
         end
         rsp_stall <= (hold_left != 0) || (stall_left != 0);
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
         end else if (stall_calm != 0) begin
            stall_calm <= stall_calm - 1;
         end else begin
            stall_left <= pick_gap();
            if ($urandom_range(0, 49) == 0) stall_calm <= $urandom_range(40, 150);
         end
      end
   end

   // long receiver hold-off so the block backs up into req_stall
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_spent <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_spent) begin
         hold_left <= HOLD_CYCLES;
         hold_spent <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_cut(logic [LB-1:0] pos, logic is_last);
      cut_item_type it;
      it.pos = pos;
      it.is_last = is_last;
      cut_backlog.push_back(it);
      queued_cuts++;
   endtask

   // hold the sender until every request is taken and every result has come back
   task automatic wait_idle();
      while (accepted_cuts != queued_cuts || due_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(mmps_pkg::csr_index_type idx, logic [LB-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == mmps_pkg::CSR_TOTAL_LENGTH) bar_length = value;
      else cut_count = value[10:0];
   endtask

   task automatic add_sets(int unsigned budget, int unsigned most_cuts);
      int unsigned     n;
      int unsigned     made;
      longint unsigned pos;
      longint unsigned span;
      made = 0;
      while (made < budget) begin
         n = $urandom_range(1, most_cuts);
         if ($urandom_range(0, 99) < 15) begin
            // noise: any order, repeats and drops back allowed
            for (int unsigned k = 0; k < n; k++)
               queue_cut($urandom_range(1, POS_MAX), k == n - 1);
         end else begin
            span = bar_length / (n + 1);
            pos = 0;
            for (int unsigned k = 0; k < n; k++) begin
               pos += 1 + $urandom_range(0, span * 2);
               if (pos > POS_MAX) pos = POS_MAX;
               queue_cut(pos[LB-1:0], k == n - 1);
            end
         end
         made += n;
      end
   endtask

   task automatic add_overflow_set(int unsigned count);
      longint unsigned pos;
      pos = 0;
      for (int unsigned k = 0; k < count; k++) begin
         pos += $urandom_range(1, 1_000_000);
         queue_cut(pos[LB-1:0], k == count - 1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, alternating bits, ties and drops back
      queue_cut(1, 1'b1);
      queue_cut(POS_MAX, 1'b1);
      queue_cut(30'h1555_5555, 1'b0);
      queue_cut(30'h2AAA_AAAA, 1'b1);
      queue_cut(500, 1'b0);
      queue_cut(500, 1'b0);
      queue_cut(100, 1'b1);
      wait_idle();

      // bar ends before the last cut
      write_reg(mmps_pkg::CSR_TOTAL_LENGTH, 1000);
      queue_cut(2000, 1'b1);
      queue_cut(300, 1'b0);
      queue_cut(600, 1'b1);
      wait_idle();

      // empty search range
      write_reg(mmps_pkg::CSR_TOTAL_LENGTH, 1);
      queue_cut(5, 1'b1);
      wait_idle();

      // too few pieces for the most cuts
      write_reg(mmps_pkg::CSR_TOTAL_LENGTH, LEN_MAX);
      write_reg(mmps_pkg::CSR_CUTS_TO_MAKE, 1024);
      queue_cut(100, 1'b0);
      queue_cut(200, 1'b1);
      wait_idle();

      write_reg(mmps_pkg::CSR_CUTS_TO_MAKE, 1);
      hold_req <= 1'b1;
      add_sets(110, 6);
      wait_idle();

      write_reg(mmps_pkg::CSR_TOTAL_LENGTH, $urandom_range(1000, 100000));
      write_reg(mmps_pkg::CSR_CUTS_TO_MAKE, 2);
      add_sets(110, 8);
      wait_idle();

      write_reg(mmps_pkg::CSR_TOTAL_LENGTH, $urandom_range(2, LEN_MAX));
      write_reg(mmps_pkg::CSR_CUTS_TO_MAKE, $urandom_range(1, 5));
      add_sets(110, 8);
      wait_idle();

      write_reg(mmps_pkg::CSR_TOTAL_LENGTH, 1);
      write_reg(mmps_pkg::CSR_CUTS_TO_MAKE, $urandom_range(1, 3));
      add_sets(30, 4);
      wait_idle();

      // full store: extra positions drop, last one included
      write_reg(mmps_pkg::CSR_TOTAL_LENGTH, LEN_MAX);
      write_reg(mmps_pkg::CSR_CUTS_TO_MAKE, 1024);
      add_overflow_set(MAXC + 6);
      add_sets(40, 4);
      wait_idle();

      write_reg(mmps_pkg::CSR_TOTAL_LENGTH, $urandom_range(50, 300));
      write_reg(mmps_pkg::CSR_CUTS_TO_MAKE, $urandom_range(1, 4));
      add_sets(110, 6);
      wait_idle();

      write_reg(mmps_pkg::CSR_TOTAL_LENGTH, $urandom_range(2, LEN_MAX));
      write_reg(mmps_pkg::CSR_CUTS_TO_MAKE, $urandom_range(1, 8));
      add_sets(110, 8);
      wait_idle();

      repeat (50) @(posedge clock);
      if (fail_count == 0 && due_answers.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
